>>> design/rtte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTT estimator package
// Request and response payload types, request codes and register indexes
// shared by the round-trip time estimator.
// ----------------------------------------------------------------------------
package rtte_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned GRAN_W = 16;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [1:0] REQ_SEND  = 2'd0;
   localparam logic [1:0] REQ_ACK   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RTO     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRANULARITY = 1'd1;

   localparam logic [WORD_W-1:0] MIN_RTO_RESET     = 32'd1000;
   localparam logic [GRAN_W-1:0] GRANULARITY_RESET = 16'd1;
   localparam logic [WORD_W-1:0] TIMEOUT_RESET     = 32'd1000;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [WORD_W-1:0] time_ms;
      logic [WORD_W-1:0] seq_num;
   } rtte_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] rto_ms;
      logic [WORD_W-1:0] srtt_ms;
      logic [WORD_W-1:0] rttvar_ms;
      logic [WORD_W-1:0] last_sample_ms;
      logic              sample_taken;
      logic              timing_busy;
   } rtte_rsp_type;

endpackage

>>> design/rtt_estimator_rto_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTT estimator with retransmission timeout
// Each request (segment sent, ack received, estimator clear) yields one
// response with the timeout, smoothed RTT, RTT variation and last sample.
//
// The request channel (req_valid, req_stall, req_data) feeds an input
// register. Response transfers leave a result register on rsp_valid,
// rsp_stall and rsp_data. A response is registered in the result register
// after its request has passed the input register. One request is taken
// every cycle while the response side keeps moving; the estimator state is
// updated from the input register, the single path that sets this rate.
// When rsp_stall is high with a response waiting, the input register holds
// its request and req_stall rises while it is full. The csr_ write port
// sets the minimum timeout and the granularity; a new value takes effect
// at the next sample. A synchronous reset empties both registers, restores
// the register defaults and returns the estimator to its initial state.
// ----------------------------------------------------------------------------
module rtt_estimator_rto_core
   import rtte_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rtte_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rtte_rsp_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   logic              in_vld_ff;
   rtte_req_type      in_data_ff;
   logic              out_vld_ff;
   rtte_rsp_type      out_data_ff;
   logic              advance;

   logic [WORD_W-1:0] min_rto_ff;
   logic [GRAN_W-1:0] granularity_ff;

   logic              timing_ff, timing_in;
   logic [WORD_W-1:0] timed_seq_ff, timed_seq_in;
   logic [WORD_W-1:0] send_time_ff, send_time_in;
   logic [WORD_W-1:0] srtt_ff, srtt_in;
   logic [WORD_W-1:0] rttvar_ff, rttvar_in;
   logic [WORD_W-1:0] timeout_ff, timeout_in;
   logic [WORD_W-1:0] sample_ff, sample_in;
   logic              have_sample_ff, have_sample_in;
   logic              sampled;

   logic [WORD_W-1:0] seq_delta;
   logic [WORD_W-1:0] new_sample;
   logic [WORD_W-1:0] abs_err;
   logic [WORD_W+1:0] var_acc;
   logic [WORD_W+2:0] srtt_acc;
   logic [WORD_W-1:0] upd_srtt;
   logic [WORD_W-1:0] upd_var;
   logic [WORD_W+1:0] var4;
   logic [WORD_W+1:0] var_term;
   logic [WORD_W+2:0] rto_sum;
   logic [WORD_W-1:0] rto_sat;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   assign seq_delta  = in_data_ff.seq_num - timed_seq_ff;
   assign new_sample = in_data_ff.time_ms - send_time_ff;
   assign abs_err    = (srtt_ff >= new_sample) ? (srtt_ff - new_sample)
                                               : (new_sample - srtt_ff);
   assign var_acc    = {2'b00, rttvar_ff} + {1'b0, rttvar_ff, 1'b0}
                       + {2'b00, abs_err};
   assign srtt_acc   = {srtt_ff, 3'b000} - {3'b000, srtt_ff}
                       + {3'b000, new_sample};
   assign upd_srtt   = have_sample_ff ? srtt_acc[WORD_W+2:3] : new_sample;
   assign upd_var    = have_sample_ff ? var_acc[WORD_W+1:2]
                                      : {1'b0, new_sample[WORD_W-1:1]};
   assign var4       = {upd_var, 2'b00};
   assign var_term   = ({{(WORD_W+2-GRAN_W){1'b0}}, granularity_ff} > var4)
                       ? {{(WORD_W+2-GRAN_W){1'b0}}, granularity_ff} : var4;
   assign rto_sum    = {3'b000, upd_srtt} + {1'b0, var_term};
   assign rto_sat    = (rto_sum[WORD_W+2:WORD_W] != 3'b000) ? '1
                                                            : rto_sum[WORD_W-1:0];

   always_comb begin
      timing_in      = timing_ff;
      timed_seq_in   = timed_seq_ff;
      send_time_in   = send_time_ff;
      srtt_in        = srtt_ff;
      rttvar_in      = rttvar_ff;
      timeout_in     = timeout_ff;
      sample_in      = sample_ff;
      have_sample_in = have_sample_ff;
      sampled        = 1'b0;
      unique case (in_data_ff.req_type)
         REQ_SEND: begin
            if (!timing_ff) begin
               timing_in    = 1'b1;
               timed_seq_in = in_data_ff.seq_num;
               send_time_in = in_data_ff.time_ms;
            end
         end
         REQ_ACK: begin
            if (timing_ff && (seq_delta != '0) && !seq_delta[WORD_W-1]) begin
               sampled        = 1'b1;
               timing_in      = 1'b0;
               srtt_in        = upd_srtt;
               rttvar_in      = upd_var;
               have_sample_in = 1'b1;
               sample_in      = new_sample;
               timeout_in     = (rto_sat < min_rto_ff) ? min_rto_ff : rto_sat;
            end
         end
         REQ_CLEAR: begin
            srtt_in        = '0;
            rttvar_in      = '0;
            have_sample_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         min_rto_ff     <= MIN_RTO_RESET;
         granularity_ff <= GRANULARITY_RESET;
         timing_ff      <= 1'b0;
         timed_seq_ff   <= '0;
         send_time_ff   <= '0;
         srtt_ff        <= '0;
         rttvar_ff      <= '0;
         timeout_ff     <= TIMEOUT_RESET;
         sample_ff      <= '0;
         have_sample_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MIN_RTO:     min_rto_ff     <= csr_wdata;
               CSR_GRANULARITY: granularity_ff <= csr_wdata[GRAN_W-1:0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            timing_ff      <= timing_in;
            timed_seq_ff   <= timed_seq_in;
            send_time_ff   <= send_time_in;
            srtt_ff        <= srtt_in;
            rttvar_ff      <= rttvar_in;
            timeout_ff     <= timeout_in;
            sample_ff      <= sample_in;
            have_sample_ff <= have_sample_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.rto_ms         <= timeout_in;
         out_data_ff.srtt_ms        <= srtt_in;
         out_data_ff.rttvar_ms      <= rttvar_in;
         out_data_ff.last_sample_ms <= sample_in;
         out_data_ff.sample_taken   <= sampled;
         out_data_ff.timing_busy    <= timing_in;
      end
   end

`ifndef SYNTH
   a_sample_ends_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_taken |-> !rsp_data.timing_busy)
      else $error("response reports a sample while timing is still busy");

   a_rto_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_taken |-> rsp_data.rto_ms >= min_rto_ff)
      else $error("timeout below the configured minimum after a sample");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");
`endif

endmodule

>>> verif/rtt_estimator_rto_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTT estimator response checker
// Watches the request, response and register ports of the estimator. For
// every request transfer it computes the expected response from its own
// copy of the estimator state and settings. It compares every response
// transfer field by field with the oldest expected response and counts
// each mismatch.
// ----------------------------------------------------------------------------
module rtt_estimator_rto_checker
   import rtte_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  rtte_req_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rtte_rsp_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata,
   output int                     mismatch_count,
   output int                     pending_count
);

   logic [WORD_W-1:0] min_rto_cfg;
   logic [GRAN_W-1:0] gran_cfg;

   logic              timing_on;
   logic [WORD_W-1:0] timed_seq;
   logic [WORD_W-1:0] send_time;
   logic [WORD_W-1:0] srtt_est;
   logic [WORD_W-1:0] rttvar_est;
   logic [WORD_W-1:0] rto_est;
   logic [WORD_W-1:0] last_rtt;
   logic              have_sample;

   rtte_rsp_type expected_estimates[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
      end
   endtask

   function automatic rtte_rsp_type estimate_step(input rtte_req_type rq);
      logic [WORD_W-1:0] ahead;
      logic [WORD_W-1:0] rtt_sample;
      logic [WORD_W-1:0] abs_diff;
      logic [WORD_W+1:0] var_sum;
      logic [WORD_W+1:0] var4;
      logic [WORD_W+1:0] var_term;
      logic [WORD_W+2:0] srtt_sum;
      logic [WORD_W+2:0] rto_sum;
      logic [WORD_W-1:0] rto_next;
      logic              took;
      rtte_rsp_type      res;
      took = 1'b0;
      ahead = rq.seq_num - timed_seq;
      case (rq.req_type)
         REQ_SEND: begin
            if (!timing_on) begin
               timing_on = 1'b1;
               timed_seq = rq.seq_num;
               send_time = rq.time_ms;
            end
         end
         REQ_ACK: begin
            if (timing_on && ahead != '0 && !ahead[WORD_W-1]) begin
               rtt_sample = rq.time_ms - send_time;
               if (!have_sample) begin
                  srtt_est = rtt_sample;
                  rttvar_est = rtt_sample >> 1;
                  have_sample = 1'b1;
               end else begin
                  abs_diff = (srtt_est >= rtt_sample) ? srtt_est - rtt_sample
                                                      : rtt_sample - srtt_est;
                  var_sum = 34'd3 * {2'b00, rttvar_est} + {2'b00, abs_diff};
                  srtt_sum = 35'd7 * {3'b000, srtt_est} + {3'b000, rtt_sample};
                  rttvar_est = var_sum[WORD_W+1:2];
                  srtt_est = srtt_sum[WORD_W+2:3];
               end
               var4 = {rttvar_est, 2'b00};
               var_term = ({18'd0, gran_cfg} > var4) ? {18'd0, gran_cfg} : var4;
               rto_sum = {3'b000, srtt_est} + {1'b0, var_term};
               rto_next = (rto_sum[WORD_W+2:WORD_W] != '0) ? '1 : rto_sum[WORD_W-1:0];
               if (rto_next < min_rto_cfg) begin
                  rto_next = min_rto_cfg;
               end
               rto_est = rto_next;
               last_rtt = rtt_sample;
               timing_on = 1'b0;
               took = 1'b1;
            end
         end
         REQ_CLEAR: begin
            srtt_est = '0;
            rttvar_est = '0;
            have_sample = 1'b0;
         end
         default: begin
         end
      endcase
      res.rto_ms = rto_est;
      res.srtt_ms = srtt_est;
      res.rttvar_ms = rttvar_est;
      res.last_sample_ms = last_rtt;
      res.sample_taken = took;
      res.timing_busy = timing_on;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rtte_rsp_type want;
      if (reset) begin
         min_rto_cfg = MIN_RTO_RESET;
         gran_cfg = GRANULARITY_RESET;
         timing_on = 1'b0;
         timed_seq = '0;
         send_time = '0;
         srtt_est = '0;
         rttvar_est = '0;
         rto_est = TIMEOUT_RESET;
         last_rtt = '0;
         have_sample = 1'b0;
         expected_estimates.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_RTO:     min_rto_cfg = csr_wdata;
               CSR_GRANULARITY: gran_cfg = csr_wdata[GRAN_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_estimates.push_back(estimate_step(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_estimates.size() == 0) begin
               report_mismatch("response transfer with no expected response");
            end else begin
               want = expected_estimates.pop_front();
               check_field("rto_ms", rsp_data.rto_ms, want.rto_ms);
               check_field("srtt_ms", rsp_data.srtt_ms, want.srtt_ms);
               check_field("rttvar_ms", rsp_data.rttvar_ms, want.rttvar_ms);
               check_field("last_sample_ms", rsp_data.last_sample_ms, want.last_sample_ms);
               check_field("sample_taken", 32'(rsp_data.sample_taken),
                           32'(want.sample_taken));
               check_field("timing_busy", 32'(rsp_data.timing_busy),
                           32'(want.timing_busy));
            end
         end
      end
      pending_count = expected_estimates.size();
   end

endmodule

>>> verif/rtt_estimator_rto_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTT estimator testbench
// Runs a short directed sequence over the request corner cases, then phases
// of random send and ack exchanges under several timeout settings, with
// random request gaps and response stalls in all but every third phase.
// A checker beside the estimator predicts and compares every response; this
// module drives the traffic and reports the verdict.
// ----------------------------------------------------------------------------
module rtt_estimator_rto_core_test;
   import rtte_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int PHASE_COUNT = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int DRAIN_LIMIT = 5000;
   localparam int RUN_LIMIT_NS = 40_000_000;

   localparam logic [WORD_W-1:0] MIN_RTO_SET [PHASE_COUNT] =
      '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd200, 32'd0, 32'd1000, 32'd3000};
   localparam logic [GRAN_W-1:0] GRAN_SET [PHASE_COUNT] =
      '{16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd500};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rtte_req_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rtte_rsp_type           rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MIN_RTO;
   logic [WORD_W-1:0]      csr_wdata = '0;

   int                mismatches;
   int                pending;
   bit                quiet = 1'b0;
   bit                rsp_jitter = 1'b0;
   int unsigned       stall_hold = 0;
   int                items_sent = 0;
   logic [WORD_W-1:0] now_ms = '0;

   rtt_estimator_rto_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rtt_estimator_rto_checker estimate_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_W-1:0] pick_rtt();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 70) return $urandom_range(1, 500);
      if (r < 92) return $urandom_range(501, 60000);
      return $urandom;
   endfunction

   function automatic logic [WORD_W-1:0] pick_advance();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 11680);
      if (r < 95) return $urandom_range(1, 32'h7FFF_FFFF);
      return 32'h7FFF_FFFF;
   endfunction

   always @(negedge clock) begin
      if (stall_hold != 0) begin
         stall_hold--;
      end else if (!rsp_jitter) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_stall = ($urandom_range(0, 9) < 3);
         stall_hold = rsp_stall ? pick_gap() : $urandom_range(0, 6);
      end
   end

   task automatic transfer_request(input logic [1:0] kind, input logic [WORD_W-1:0] t,
                                   input logic [WORD_W-1:0] s);
      int unsigned gap;
      req_data.req_type = kind;
      req_data.time_ms = t;
      req_data.seq_num = s;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [WORD_W-1:0] data);
      csr_index = index;
      csr_wdata = data;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_exchange();
      logic [WORD_W-1:0] seq0;
      logic [WORD_W-1:0] t0;
      logic [WORD_W-1:0] rtt;
      int unsigned       r;
      seq0 = $urandom;
      t0 = now_ms;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         transfer_request(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else if (r < 5) begin
         transfer_request(REQ_ACK, t0, $urandom);
      end
      transfer_request(REQ_SEND, t0, seq0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         transfer_request(REQ_SEND, t0 + $urandom_range(0, 100), $urandom);
      end else if (r < 12) begin
         transfer_request(REQ_ACK, t0 + 1, seq0);
      end else if (r < 16) begin
         transfer_request(REQ_ACK, t0 + 2, seq0 - $urandom_range(1, 5000));
      end else if (r < 19) begin
         transfer_request(REQ_ACK, t0 + 3, seq0 + 32'h8000_0000 + $urandom_range(0, 3));
      end else if (r < 23) begin
         transfer_request(REQ_UNKNOWN, $urandom, $urandom);
      end else if (r < 27) begin
         transfer_request(REQ_CLEAR, $urandom, $urandom);
      end
      rtt = pick_rtt();
      transfer_request(REQ_ACK, t0 + rtt, seq0 + pick_advance());
      now_ms = t0 + rtt + $urandom_range(0, 40);
      if ($urandom_range(0, 99) == 0) begin
         now_ms = $urandom;
      end
   endtask

   initial begin
      int waited;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      transfer_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      transfer_request(REQ_ACK, 32'd50, 32'd1);
      transfer_request(REQ_SEND, 32'd100, 32'd1000);
      transfer_request(REQ_SEND, 32'd200, 32'd5000);
      transfer_request(REQ_ACK, 32'd300, 32'd1000);
      transfer_request(REQ_ACK, 32'd300, 32'd999);
      transfer_request(REQ_ACK, 32'd300, 32'd1000 + 32'h8000_0000);
      transfer_request(REQ_ACK, 32'd350, 32'd1000 + 32'h7FFF_FFFF);
      transfer_request(REQ_SEND, 32'd400, 32'd2000);
      transfer_request(REQ_ACK, 32'd1400, 32'd2001);
      transfer_request(REQ_SEND, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      transfer_request(REQ_ACK, 32'd10, 32'd0);
      transfer_request(REQ_SEND, 32'd0, 32'd0);
      transfer_request(REQ_ACK, 32'd0, 32'd1);
      transfer_request(REQ_CLEAR, 32'd0, 32'd0);
      transfer_request(REQ_SEND, 32'd5, 32'd7);
      transfer_request(REQ_ACK, 32'd4, 32'd8);
      transfer_request(REQ_SEND, 32'd10, 32'd20);
      transfer_request(REQ_ACK, 32'd11, 32'd21);
      transfer_request(REQ_SEND, 32'd20, 32'd30);
      transfer_request(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      transfer_request(REQ_ACK, 32'd90, 32'd40);
      transfer_request(REQ_UNKNOWN, 32'd0, 32'd0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         quiet = (p % 3 == 2);
         rsp_jitter = !quiet;
         if (p == 5) begin
            write_csr(CSR_MIN_RTO, $urandom);
            write_csr(CSR_GRANULARITY, $urandom);
         end else begin
            write_csr(CSR_MIN_RTO, MIN_RTO_SET[p]);
            write_csr(CSR_GRANULARITY, ($urandom & 32'hFFFF_0000) | GRAN_SET[p]);
         end
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            run_exchange();
            if ($urandom_range(0, 99) == 0) begin
               drain();
            end
         end
      end

      req_valid = 1'b0;
      waited = 0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
